>>> src/nbpt_pkg.sv
// shared types and constants for the naive bayes pixel trainer
`default_nettype none
package nbpt_pkg;

    // action codes of an input beat
    localparam logic [1:0] ACT_PIXEL = 2'd0;
    localparam logic [1:0] ACT_END   = 2'd1;
    localparam logic [1:0] ACT_LIKE  = 2'd2;
    localparam logic [1:0] ACT_PRIOR = 2'd3;

    // pixel characters
    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    localparam int          NUM_SHADES = 2;
    localparam int          VALUE_W    = 17;
    localparam int          QUOT_BITS  = 17;
    localparam logic [16:0] Q_ONE      = 17'h10000;
    localparam logic [7:0]  K_RESET    = 8'd16;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage
`default_nettype wire

>>> src/nbpt_ram.sv
// generic single write port ram with registered read
`default_nettype none
module nbpt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> src/nbpt_div.sv
// restoring divider, one quotient bit per cycle, num < den assumed
`default_nettype none
module nbpt_div #(
    parameter int WIDTH = 21
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [WIDTH-1:0]     num,
    input  wire logic [WIDTH-1:0]     den,
    output nbpt_pkg::div_status_t     stat,
    output logic [nbpt_pkg::QUOT_BITS-1:0] quot
);
    import nbpt_pkg::*;

    localparam int CNT_W = $clog2(QUOT_BITS + 1);

    logic [WIDTH-1:0]     rem_reg, rem_next;
    logic [WIDTH-1:0]     den_reg, den_next;
    logic [QUOT_BITS-1:0] quot_reg, quot_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [WIDTH:0]       rem2;
    logic                 ge;

    // shifted remainder against divisor
    assign rem2 = {rem_reg, 1'b0};
    assign ge   = (rem2 >= {1'b0, den_reg});

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = num;
            den_next  = den;
            quot_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? WIDTH'(rem2 - {1'b0, den_reg}) : WIDTH'(rem2);
            quot_next = {quot_reg[QUOT_BITS-2:0], ge};
            cnt_next  = CNT_W'(cnt_reg + CNT_W'(1));
            if (cnt_reg == CNT_W'(QUOT_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quot_reg;

endmodule
`default_nettype wire

>>> src/naive_bayes_pixel_trainer_top.sv
// naive bayes pixel trainer: count tables, sequencer and output register
// pixel and end-of-image beats go through accept, ram read and update; queries go
// through accept, ram read, operand setup, a check and, when it is needed, the 17-step shared
// divider, then wait for the output register (a prior with no image skips the check);
// one beat is in work at a time, so no new beat is taken until the last is done
// reset: a clearing pass writes zero to every count, with input stalled; laplace_k
// resets to 16 (1.0)
`default_nettype none
module naive_bayes_pixel_trainer_top #(
    parameter int IMAGE_SIZE  = 28,
    parameter int NUM_CLASSES = 10,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        laplace_k_wen,
    input  wire logic [7:0]  laplace_k,
    // input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  action,
    input  wire logic [4:0]  row,
    input  wire logic [4:0]  col,
    input  wire logic [3:0]  class_label,
    input  wire logic [7:0]  pixel_char,
    input  wire logic        shade,
    // output channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [16:0]      value,
    output logic             status
);
    import nbpt_pkg::*;

    localparam int DEPTH = IMAGE_SIZE * IMAGE_SIZE * NUM_CLASSES * NUM_SHADES;
    localparam int AW    = $clog2(DEPTH);
    localparam int CAW   = $clog2(NUM_CLASSES);
    localparam int CW    = COUNT_WIDTH;
    // 16*count + 2*k needs four bits for the shift and one for the carry
    localparam int DW    = COUNT_WIDTH + 5;

    // sequencer states
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_EXEC  = 3'd3;
    localparam logic [2:0] ST_PREP  = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_RESP  = 3'd6;

    logic [2:0]         state_reg, state_next;
    logic [AW-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [7:0]         k_reg, k_next;
    logic [CW-1:0]      total_reg, total_next;

    // latched beat
    logic [1:0]         act_reg, act_next;
    logic [4:0]         row_reg, row_next;
    logic [4:0]         col_reg, col_next;
    logic [3:0]         cls_reg, cls_next;
    logic               shd_reg, shd_next;
    logic               chr_ok_reg, chr_ok_next;
    logic [AW-1:0]      addr_reg, addr_next;

    // divider operands and pending result
    logic [DW-1:0]      num_reg, num_next;
    logic [DW-1:0]      den_reg, den_next;
    logic [16:0]        pend_value_reg, pend_value_next;
    logic               pend_status_reg, pend_status_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [16:0]        out_value_reg, out_value_next;
    logic               out_status_reg, out_status_next;

    logic               in_accept;
    logic               out_free;
    logic               pos_ok;
    logic               cls_ok;
    logic               is_ink;
    logic [AW-1:0]      addr_calc;

    // ram ports
    logic               sh_we;
    logic [AW-1:0]      sh_waddr;
    logic [CW-1:0]      sh_wdata;
    logic [AW-1:0]      sh_raddr;
    logic [CW-1:0]      sh_rdata;
    logic               cl_we;
    logic [CAW-1:0]     cl_waddr;
    logic [CW-1:0]      cl_wdata;
    logic [CAW-1:0]     cl_raddr;
    logic [CW-1:0]      cl_rdata;

    // divider
    logic               div_start;
    div_status_t        div_stat;
    logic [QUOT_BITS-1:0] div_quot;

    // counts as seen by the query, masked when out of range
    logic [CW-1:0]      c_eff;
    logic [CW-1:0]      n_eff;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign pos_ok = (7'(row_reg) < 7'(IMAGE_SIZE)) && (7'(col_reg) < 7'(IMAGE_SIZE));
    assign cls_ok = (7'(cls_reg) < 7'(NUM_CLASSES));
    assign is_ink = (pixel_char == CHAR_HASH) || (pixel_char == CHAR_PLUS);

    // flat table index of (row, col, class, shade)
    assign addr_calc = AW'((((int'(row_reg) * IMAGE_SIZE + int'(col_reg)) * NUM_CLASSES
                           + int'(cls_reg)) * NUM_SHADES) + int'(shd_reg));

    assign c_eff = (pos_ok && cls_ok) ? sh_rdata : '0;
    assign n_eff = cls_ok ? cl_rdata : '0;

    // ram read addresses, parked at zero when out of range
    assign sh_raddr = (pos_ok && cls_ok) ? addr_calc : '0;
    assign cl_raddr = cls_ok ? CAW'(cls_reg) : '0;

    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        k_next           = laplace_k_wen ? laplace_k : k_reg;
        total_next       = total_reg;
        act_next         = act_reg;
        row_next         = row_reg;
        col_next         = col_reg;
        cls_next         = cls_reg;
        shd_next         = shd_reg;
        chr_ok_next      = chr_ok_reg;
        addr_next        = addr_reg;
        num_next         = num_reg;
        den_next         = den_reg;
        pend_value_next  = pend_value_reg;
        pend_status_next = pend_status_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_value_next   = out_value_reg;
        out_status_next  = out_status_reg;
        sh_we            = 1'b0;
        sh_waddr         = addr_reg;
        sh_wdata         = '0;
        cl_we            = 1'b0;
        cl_waddr         = CAW'(cls_reg);
        cl_wdata         = '0;
        div_start        = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                // one entry of the shade table per cycle, and of the class table while the counter is below NUM_CLASSES
                sh_we    = 1'b1;
                sh_waddr = clr_cnt_reg;
                if (clr_cnt_reg < AW'(NUM_CLASSES))
                begin
                    cl_we    = 1'b1;
                    cl_waddr = CAW'(clr_cnt_reg);
                end
                clr_cnt_next = AW'(clr_cnt_reg + AW'(1));
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    act_next    = action;
                    row_next    = row;
                    col_next    = col;
                    cls_next    = class_label;
                    // a sample takes its shade from the character, a query from the field
                    shd_next    = (action == ACT_PIXEL) ? is_ink : shade;
                    chr_ok_next = is_ink || (pixel_char == CHAR_SPACE);
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                addr_next  = addr_calc;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                case (act_reg)
                    ACT_PIXEL:
                    begin
                        if (chr_ok_reg && pos_ok && cls_ok)
                        begin
                            sh_we    = 1'b1;
                            sh_wdata = (sh_rdata == '1) ? sh_rdata
                                                        : CW'(sh_rdata + CW'(1));
                        end
                        state_next = ST_IDLE;
                    end
                    ACT_END:
                    begin
                        if (cls_ok)
                        begin
                            cl_we      = 1'b1;
                            cl_wdata   = (cl_rdata == '1) ? cl_rdata
                                                          : CW'(cl_rdata + CW'(1));
                            total_next = (total_reg == '1) ? total_reg
                                                           : CW'(total_reg + CW'(1));
                        end
                        state_next = ST_IDLE;
                    end
                    ACT_LIKE:
                    begin
                        num_next         = (DW'(c_eff) << 4) + DW'(k_reg);
                        den_next         = (DW'(n_eff) << 4) + (DW'(k_reg) << 1);
                        pend_status_next = 1'b0;
                        state_next       = ST_PREP;
                    end
                    default:
                    begin
                        num_next = DW'(n_eff);
                        den_next = DW'(total_reg);
                        if (total_reg == '0)
                        begin
                            // no image seen yet
                            pend_value_next  = '0;
                            pend_status_next = 1'b1;
                            state_next       = ST_RESP;
                        end
                        else
                        begin
                            pend_status_next = 1'b0;
                            state_next       = ST_PREP;
                        end
                    end
                endcase
            end
            ST_PREP:
            begin
                if (den_reg == '0)
                begin
                    // zero smoothing on an empty class
                    pend_value_next = '0;
                    state_next      = ST_RESP;
                end
                else if (num_reg >= den_reg)
                begin
                    // ratio at or above one saturates
                    pend_value_next = Q_ONE;
                    state_next      = ST_RESP;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    // 17th quotient bit rounds half up
                    pend_value_next = {1'b0, div_quot[QUOT_BITS-1:1]}
                                    + {{(QUOT_BITS-1){1'b0}}, div_quot[0]};
                    state_next      = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = pend_value_reg;
                    out_status_next = pend_status_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            k_reg         <= K_RESET;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            k_reg         <= k_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg         <= act_next;
        row_reg         <= row_next;
        col_reg         <= col_next;
        cls_reg         <= cls_next;
        shd_reg         <= shd_next;
        chr_ok_reg      <= chr_ok_next;
        addr_reg        <= addr_next;
        num_reg         <= num_next;
        den_reg         <= den_next;
        pend_value_reg  <= pend_value_next;
        pend_status_reg <= pend_status_next;
        out_value_reg   <= out_value_next;
        out_status_reg  <= out_status_next;
    end

    // per position, class and shade counts
    nbpt_ram #(
        .WIDTH (CW),
        .DEPTH (DEPTH)
    ) u_shade_ram (
        .clk   (clk),
        .we    (sh_we),
        .waddr (sh_waddr),
        .wdata (sh_wdata),
        .raddr (sh_raddr),
        .rdata (sh_rdata)
    );

    // per class image counts
    nbpt_ram #(
        .WIDTH (CW),
        .DEPTH (NUM_CLASSES)
    ) u_class_ram (
        .clk   (clk),
        .we    (cl_we),
        .waddr (cl_waddr),
        .wdata (cl_wdata),
        .raddr (cl_raddr),
        .rdata (cl_rdata)
    );

    // shared divider for both query kinds
    nbpt_div #(
        .WIDTH (DW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (den_reg),
        .stat  (div_stat),
        .quot  (div_quot)
    );

    assign out_valid = out_valid_reg;
    assign value     = out_value_reg;
    assign status    = out_status_reg;

    // no beat taken during the clearing pass
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> in_stall)
        else $error("input accepted while clearing");

    // divider finishes only while the sequencer waits on it
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == ST_DIV)
        else $error("divider done outside divide state");

    // divide state is covered by a running or finishing divider
    a_div_alive: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> (div_stat.busy || div_stat.done))
        else $error("waiting on an idle divider");

    // updates return to idle and give no result
    a_update_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EXEC && (act_reg == ACT_PIXEL || act_reg == ACT_END)
        |=> state_reg == ST_IDLE && out_valid == $past(out_valid && out_stall))
        else $error("update produced a result");

    // a pending result waits while the output register is full and stalled
    a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RESP && !out_free |=> state_reg == ST_RESP)
        else $error("pending result dropped");

endmodule
`default_nettype wire
